FILE: rtl/core/qac_pkg.sv
// Shared types and constants for the quadratic assignment cost block.
package qac_pkg;

  localparam int unsigned ROW_W   = 4;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned DIST_W  = 8;
  localparam int unsigned FLOW_W  = 8;
  localparam int unsigned X_W     = 16;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned PROD_W  = DIST_W + FLOW_W;
  localparam int unsigned ACC_W   = COST_W + 1;
  localparam int unsigned IN_DW   = ROW_W + COL_W + DIST_W + FLOW_W + X_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(12);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } qac_state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // a read of one (s,t,i,j) term goes out this cycle
    logic load;   // move the finished sum into the output register
  } qac_ctl_t;

  // Q2.14 value at or above 1.0: sign clear and bit 14 set
  function automatic logic is_assigned(input logic signed [X_W-1:0] x);
    return !x[X_W-1] && x[X_W-2];
  endfunction

endpackage

FILE: rtl/core/qac_store.sv
// Cell stores: distance, flow and assigned bit, one write port, registered reads.
module qac_store import qac_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DIST_W-1:0] wdist_i,
  input  logic [FLOW_W-1:0] wflow_i,
  input  logic              wasg_i,
  input  logic [AW-1:0]     dist_raddr_i,
  input  logic [AW-1:0]     flow_raddr_i,
  input  logic [AW-1:0]     asg_a_raddr_i,
  input  logic [AW-1:0]     asg_b_raddr_i,
  output logic [DIST_W-1:0] dist_o,
  output logic [FLOW_W-1:0] flow_o,
  output logic              asg_a_o,
  output logic              asg_b_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [FLOW_W-1:0] flow_mem [DEPTH];
  logic              asg_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dist_mem[waddr_i] <= wdist_i;
      flow_mem[waddr_i] <= wflow_i;
      asg_mem[waddr_i]  <= wasg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_o  <= dist_mem[dist_raddr_i];
    flow_o  <= flow_mem[flow_raddr_i];
    asg_a_o <= asg_mem[asg_a_raddr_i];
    asg_b_o <= asg_mem[asg_b_raddr_i];
  end

endmodule

FILE: rtl/core/qac_mac.sv
// Shared multiply-accumulate unit with saturating 33-bit accumulator.
module qac_mac import qac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qac_ctl_t          ctl_i,
  input  logic [DIST_W-1:0] dist_i,
  input  logic [FLOW_W-1:0] flow_i,
  input  logic              asg_a_i,
  input  logic              asg_b_i,
  output logic              busy_o,
  output logic [COST_W-1:0] cost_o
);

  logic              rd_v_q, prod_v_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              both;

  assign both = asg_a_i & asg_b_i;
  // zero operands when the pair is not assigned
  assign prod_d = PROD_W'(both ? dist_i : '0) * PROD_W'(both ? flow_i : '0);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q && !acc_q[ACC_W-1]) begin
      // top bit is sticky: once past 32 bits the sum stays saturated
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      rd_v_q   <= ctl_i.issue;
      prod_v_q <= rd_v_q;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign busy_o = rd_v_q | prod_v_q;
  assign cost_o = acc_q[ACC_W-1] ? '1 : acc_q[COST_W-1:0];

endmodule

FILE: rtl/core/qac_seq.sv
// Walk sequencer: steps (s,i,t,j) over the n-by-n cells and hands off the sum.
module qac_seq import qac_pkg::*; #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned NW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    n_i,
  input  logic             busy_i,
  input  logic             out_free_i,
  output logic             ready_o,
  output qac_ctl_t         ctl_o,
  output logic [IDX_W-1:0] s_o,
  output logic [IDX_W-1:0] i_o,
  output logic [IDX_W-1:0] t_o,
  output logic [IDX_W-1:0] j_o
);

  qac_state_e       state_q, state_d;
  logic [IDX_W-1:0] s_q, s_d, i_q, i_d, t_q, t_d, j_q, j_d;
  logic [NW-1:0]    nm1;
  logic [IDX_W-1:0] top;
  logic             s_end, i_end, t_end, j_end;

  assign nm1   = n_i - NW'(1);
  assign top   = nm1[IDX_W-1:0];
  assign s_end = (s_q == top);
  assign i_end = (i_q == top);
  assign t_end = (t_q == top);
  assign j_end = (j_q == top);

  always_comb begin
    state_d = state_q;
    s_d = s_q;
    i_d = i_q;
    t_d = t_q;
    j_d = j_q;
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.clear = 1'b1;
          s_d = '0;
          i_d = '0;
          t_d = '0;
          j_d = '0;
          state_d = (n_i == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        ctl_o.issue = 1'b1;
        j_d = j_end ? '0 : j_q + IDX_W'(1);
        if (j_end) begin
          t_d = t_end ? '0 : t_q + IDX_W'(1);
          if (t_end) begin
            i_d = i_end ? '0 : i_q + IDX_W'(1);
            if (i_end) begin
              s_d = s_q + IDX_W'(1);
              if (s_end) begin
                state_d = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctl_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_q <= '0;
      i_q <= '0;
      t_q <= '0;
      j_q <= '0;
    end else begin
      state_q <= state_d;
      s_q <= s_d;
      i_q <= i_d;
      t_q <= t_d;
      j_q <= j_d;
    end
  end

  assign ready_o = (state_q == ST_IDLE);
  assign s_o = s_q;
  assign i_o = i_q;
  assign t_o = t_q;
  assign j_o = j_q;

endmodule

FILE: rtl/core/qap_assignment_cost.sv
// Top level: Koopmans-Beckmann quadratic assignment cost evaluator.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata cell (40b), tlast = last
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata cost (32b)
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i = problem_size (5b)
//
// Cell beats load one per cycle while the sequencer is idle. After the beat with
// tlast the sequencer walks all n^4 (s,t,i,j) terms through the one shared
// multiplier, one term a cycle, and offers the cost beat once the pipeline drains;
// s_axis is not ready from tlast until that beat is loaded. Reset (rst_ni, async,
// active low) sets n to 12 and clears control; the cell stores are not cleared.
// A stalled cost beat holds in the output register while new cells load; the
// next walk result waits until that register is free.
module qap_assignment_cost import qac_pkg::*; #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] row_index, [7:4] col_index, [15:8] distance, [23:16] flow,
  // [39:24] x_value (signed Q2.14)
  input  logic [IN_DW-1:0]  s_axis_tdata,
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [31:0] cost
  output logic [COST_W-1:0] m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_SIZE);
  localparam int unsigned AW    = 2 * IDX_W;
  localparam int unsigned NW    = $clog2(MAX_SIZE + 1);

  // input beat fields
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic [DIST_W-1:0]       dist_in;
  logic [FLOW_W-1:0]       flow_in;
  logic signed [X_W-1:0]   x_in;
  logic [IDX_W+ROW_W-1:0]  row_w;
  logic [IDX_W+COL_W-1:0]  col_w;
  logic                    in_range;
  logic                    accept;

  logic [SIZE_W-1:0]       size_q;
  logic [NW-1:0]           n;

  qac_ctl_t                ctl;
  logic                    busy;
  logic [IDX_W-1:0]        s_idx, i_idx, t_idx, j_idx;
  logic [DIST_W-1:0]       dist_rd;
  logic [FLOW_W-1:0]       flow_rd;
  logic                    asg_a, asg_b;
  logic [COST_W-1:0]       cost;

  logic                    out_valid_q;
  logic [COST_W-1:0]       out_data_q;
  logic                    out_free;

  assign row     = s_axis_tdata[ROW_W-1:0];
  assign col     = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign dist_in = s_axis_tdata[ROW_W+COL_W+DIST_W-1:ROW_W+COL_W];
  assign flow_in = s_axis_tdata[ROW_W+COL_W+DIST_W+FLOW_W-1:ROW_W+COL_W+DIST_W];
  assign x_in    = s_axis_tdata[IN_DW-1:IN_DW-X_W];

  assign row_w    = {{IDX_W{1'b0}}, row};
  assign col_w    = {{IDX_W{1'b0}}, col};
  // cells outside the array are dropped; tlast still starts the walk
  assign in_range = (32'(row) < MAX_SIZE) && (32'(col) < MAX_SIZE);
  assign accept   = s_axis_tvalid & s_axis_tready;

  // config register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // sizes past the array clamp to MAX_SIZE
  assign n = (32'(size_q) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_q);

  qac_seq #(
    .IDX_W(IDX_W),
    .NW   (NW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept & s_axis_tlast),
    .n_i       (n),
    .busy_i    (busy),
    .out_free_i(out_free),
    .ready_o   (s_axis_tready),
    .ctl_o     (ctl),
    .s_o       (s_idx),
    .i_o       (i_idx),
    .t_o       (t_idx),
    .j_o       (j_idx)
  );

  // address = {row, col}; terms read d(i,j), f(s,t), a(s,i), a(t,j)
  qac_store #(
    .AW(AW)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (accept & in_range),
    .waddr_i      ({row_w[IDX_W-1:0], col_w[IDX_W-1:0]}),
    .wdist_i      (dist_in),
    .wflow_i      (flow_in),
    .wasg_i       (is_assigned(x_in)),
    .dist_raddr_i ({i_idx, j_idx}),
    .flow_raddr_i ({s_idx, t_idx}),
    .asg_a_raddr_i({s_idx, i_idx}),
    .asg_b_raddr_i({t_idx, j_idx}),
    .dist_o       (dist_rd),
    .flow_o       (flow_rd),
    .asg_a_o      (asg_a),
    .asg_b_o      (asg_b)
  );

  qac_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .dist_i (dist_rd),
    .flow_i (flow_rd),
    .asg_a_i(asg_a),
    .asg_b_i(asg_b),
    .busy_o (busy),
    .cost_o (cost)
  );

  // output register: holds a stalled cost beat
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      out_data_q <= cost;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: verif/tb_top.sv
// Self-checking stream testbench for the quadratic assignment cost block.
`timescale 1ns / 100ps

module tb_top;
  import qac_pkg::*;

  localparam int unsigned MAX_N     = 16;        // matches the DUT's MAX_SIZE
  localparam int unsigned CELLS     = MAX_N * MAX_N;
  localparam int          ONE_Q14   = 16384;     // 1.0 in Q2.14
  localparam int unsigned RAND_BEATS = 1000;
  localparam int unsigned SETTLE    = 12;        // quiet cycles before a size change
  localparam int unsigned ERR_PRINT = 40;
  // Watchdog limit in ns, with ample margin over the worst correct run.
  localparam longint      TIMEOUT_NS = 64'd72_000_000;

  // One cell beat as the driver sees it; low fields land in the low tdata bits.
  typedef struct packed {
    logic              last;
    logic [X_W-1:0]    x;
    logic [FLOW_W-1:0] flow;
    logic [DIST_W-1:0] distance;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cell_beat_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [3:0] row_index, [7:4] col_index, [15:8] distance, [23:16] flow,
  // [39:24] x_value (signed Q2.14)
  logic [IN_DW-1:0]  s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [31:0] cost
  logic [COST_W-1:0] m_axis_tdata;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_data_i    = '0;

  qap_assignment_cost #(.MAX_SIZE(MAX_N)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: cell stores, size register and costs still owed.
  // Cells change on accepted beats only, so they track the DUT regardless of timing.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] dist_cell  [CELLS];
  logic [FLOW_W-1:0] flow_cell  [CELLS];
  logic              taken_cell [CELLS];
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  logic [COST_W-1:0] cost_due [$];

  cell_beat_t  cell_q [$];          // beats waiting for the driver
  cell_beat_t  nxt_beat;
  cell_beat_t  seen_beat;
  int unsigned beats_sent    = 0;
  int unsigned beats_taken   = 0;
  int unsigned rand_beats    = 0;
  int unsigned costs_checked = 0;
  int unsigned sizes_set     = 0;
  int unsigned errors        = 0;

  int unsigned s_gap   = 0;
  bit          s_burst = 1'b0;
  int unsigned m_hold  = 0;
  int unsigned m_draw;
  bit          m_burst = 1'b0;

  // Koopmans-Beckmann sum over every (s,t,i,j) inside the active size where
  // facility s sits at i and facility t sits at j.
  function automatic logic [COST_W-1:0] assignment_cost();
    int unsigned n;
    logic [63:0] sum;
    n   = (size_reg > MAX_N) ? MAX_N : int'(size_reg);
    sum = '0;
    for (int s = 0; s < n; s++)
      for (int i = 0; i < n; i++)
        if (taken_cell[s*MAX_N + i])
          for (int t = 0; t < n; t++)
            for (int j = 0; j < n; j++)
              if (taken_cell[t*MAX_N + j])
                sum += 64'(dist_cell[i*MAX_N + j]) * 64'(flow_cell[s*MAX_N + t]);
    return (sum > 64'hFFFF_FFFF) ? '1 : sum[COST_W-1:0];
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= ERR_PRINT)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Cell driver: one beat per handshake, random gap after each beat, with
  // occasional back-to-back bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_gap != 0) begin
        s_gap         <= s_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cell_q.size() != 0) begin
        nxt_beat      = cell_q.pop_front();
        s_axis_tdata  <= nxt_beat[IN_DW-1:0];
        s_axis_tlast  <= nxt_beat.last;
        s_axis_tvalid <= 1'b1;
        s_gap         <= s_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 63) == 0)
          s_burst <= !s_burst;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Input monitor: every accepted cell goes into the shadow stores; tlast
  // closes the run and queues the cost the walk must produce.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen_beat = {s_axis_tlast, s_axis_tdata};
      dist_cell [seen_beat.row*MAX_N + seen_beat.col] = seen_beat.distance;
      flow_cell [seen_beat.row*MAX_N + seen_beat.col] = seen_beat.flow;
      taken_cell[seen_beat.row*MAX_N + seen_beat.col] = $signed(seen_beat.x) >= ONE_Q14;
      if (seen_beat.last)
        cost_due.push_back(assignment_cost());
      beats_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Cost sink: random backpressure, a drawn hold after each beat, and bursts
  // of constant ready. Each cost beat is matched against the oldest owed cost.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (cost_due.size() == 0) begin
        report($sformatf("cost beat %0d with nothing owed", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== cost_due[0])
          report($sformatf("cost got %0d, want %0d", m_axis_tdata, cost_due[0]));
        void'(cost_due.pop_front());
      end
      costs_checked++;
      m_draw = m_burst ? 0 : $urandom_range(0, 12);
      m_hold        <= m_draw;
      m_axis_tready <= (m_draw == 0);
      if ($urandom_range(0, 7) == 0)
        m_burst <= !m_burst;
    end else if (m_hold != 0) begin
      m_hold        <= m_hold - 1;
      m_axis_tready <= (m_hold == 1);
    end else begin
      m_axis_tready <= m_burst || ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cell(input int unsigned r, input int unsigned c,
                           input int unsigned d, input int unsigned f,
                           input logic [X_W-1:0] x, input bit last);
    cell_beat_t b;
    b.row      = ROW_W'(r);
    b.col      = COL_W'(c);
    b.distance = DIST_W'(d);
    b.flow     = FLOW_W'(f);
    b.x        = x;
    b.last     = last;
    cell_q.push_back(b);
    beats_sent++;
  endtask

  // Wait until every beat is in and every cost is out, then let the block
  // finish any cell write still in flight.
  task automatic drain();
    while (beats_taken != beats_sent || cost_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Size writes only happen with the block idle (after drain).
  task automatic set_size(input logic [SIZE_W-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    size_reg = v;
    sizes_set++;
  endtask

  // A run of cells for size n. Normal runs put x at or above 1.0 on the cells
  // that land on a random permutation, add random cells and end on tlast;
  // noise runs scatter cells anywhere and leave the run open for the next one.
  task automatic queue_frame(input int unsigned n, input bit noise);
    int unsigned span, k, r, c, tmp, pick;
    int unsigned perm [MAX_N];
    logic [X_W-1:0] x;
    span = (n == 0) ? 1 : ((n > MAX_N) ? MAX_N : n);
    for (int q = 0; q < MAX_N; q++) perm[q] = q;
    for (int q = span - 1; q > 0; q--) begin
      pick       = $urandom_range(0, q);
      tmp        = perm[q];
      perm[q]    = perm[pick];
      perm[pick] = tmp;
    end
    k = noise ? $urandom_range(1, 6) : $urandom_range(span, span*span + span);
    for (int m = 0; m < k; m++) begin
      if (noise || $urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, MAX_N - 1);
        c = $urandom_range(0, MAX_N - 1);
      end else begin
        r = $urandom_range(0, span - 1);
        c = $urandom_range(0, span - 1);
      end
      if (!noise && c == perm[r])
        x = ($urandom_range(0, 5) != 0) ? X_W'(ONE_Q14) : X_W'($urandom_range(16384, 32767));
      else if ($urandom_range(0, 7) == 0)
        x = X_W'(ONE_Q14 - 1);                       // just short of 1.0
      else
        x = X_W'($urandom_range(0, 65535));
      push_cell(r, c, $urandom_range(0, 255), $urandom_range(0, 255), x,
                !noise && m == k - 1);
    end
    rand_beats += k;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n, frames;
    int unsigned fill_perm [MAX_N];
    int unsigned pick, tmp;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Write all 256 cells once so no later walk can touch an unwritten cell.
    // Runs at the reset size of 12 with a permutation placed over the grid.
    for (int q = 0; q < MAX_N; q++) fill_perm[q] = q;
    for (int q = MAX_N - 1; q > 0; q--) begin
      pick            = $urandom_range(0, q);
      tmp             = fill_perm[q];
      fill_perm[q]    = fill_perm[pick];
      fill_perm[pick] = tmp;
    end
    for (int r = 0; r < MAX_N; r++)
      for (int c = 0; c < MAX_N; c++)
        push_cell(r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                  (c == fill_perm[r]) ? X_W'(ONE_Q14) : X_W'($urandom_range(0, 65535)),
                  r == MAX_N - 1 && c == MAX_N - 1);
    drain();

    // Full size: extreme values, x at the Q2.14 limits and around 1.0.
    set_size(SIZE_W'(MAX_N));
    push_cell(0, 0, 255, 255, 16'h7FFF, 1'b0);             // far above 1.0: taken
    push_cell(15, 15, 0, 0, 16'h8000, 1'b0);                // most negative: not taken
    push_cell(15, 0, 255, 255, 16'h3FFF, 1'b0);             // just below 1.0
    push_cell(0, 15, 255, 255, 16'h4001, 1'b1);             // just above 1.0
    drain();

    // Size beyond MAX_SIZE saturates to the full grid.
    set_size('1);
    push_cell(7, 7, 255, 255, 16'h4000, 1'b1);
    drain();

    // Size zero: empty walk, cost zero.
    set_size('0);
    push_cell(3, 4, 255, 255, 16'hC000, 1'b1);              // -1.0
    drain();

    // Single facility: one term, then the same cell dropped.
    set_size(SIZE_W'(1));
    push_cell(0, 0, 255, 255, 16'h4000, 1'b1);
    push_cell(0, 0, 255, 255, 16'h0000, 1'b1);
    drain();

    // 2x2 with every cell taken at full scale, then tlast on a cell outside n.
    set_size(SIZE_W'(2));
    push_cell(0, 0, 255, 255, 16'h4000, 1'b0);
    push_cell(0, 1, 255, 255, 16'h4000, 1'b0);
    push_cell(1, 0, 255, 255, 16'h4000, 1'b0);
    push_cell(1, 1, 255, 255, 16'h4000, 1'b1);
    push_cell(9, 3, 17, 42, 16'h2000, 1'b1);
    drain();

    // Random phases: mostly small sizes, now and then size 12.
    while (rand_beats < RAND_BEATS) begin
      n = ($urandom_range(0, 11) == 0) ? 12 : $urandom_range(0, 8);
      set_size(SIZE_W'(n));
      frames = (n == 12) ? 1 : $urandom_range(2, 8);
      repeat (frames) queue_frame(n, $urandom_range(0, 7) == 0);
      drain();
    end

    $display("Covered %0d cell beats (%0d random) over %0d size settings",
             beats_sent, rand_beats, sizes_set);
    $display("Checked %0d cost beats, %0d mismatches", costs_checked, errors);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d costs owed", cost_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qac_pkg.sv
rtl/core/qac_store.sv
rtl/core/qac_mac.sv
rtl/core/qac_seq.sv
rtl/core/qap_assignment_cost.sv
verif/tb_top.sv
